FILE: hdl/ppmd_pkg.sv
// Shared types and constants for the PPM sum-signal decoder.
// No dependencies; imported by ppmd_frame and ppm_sum_decoder.
`default_nettype none

package ppmd_pkg;

  localparam int DEFAULT_NUM_CHANNELS = 8;
  localparam int DEFAULT_STAMP_WIDTH  = 32;

  localparam int TICK_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CHAN_W    = 4;
  localparam int SIDX_W    = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_MIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_MAX = 2'd3;

  localparam logic [TICK_W-1:0] SYNC_MIN_RESET = 32'd3000;
  localparam logic [TICK_W-1:0] SYNC_MAX_RESET = 32'd30000;
  localparam logic [TICK_W-1:0] DATA_MIN_RESET = 32'd800;
  localparam logic [TICK_W-1:0] DATA_MAX_RESET = 32'd2200;

  // pulse store reset: mid-stick everywhere, throttle channel (index 2) low
  localparam logic [TICK_W-1:0] PULSE_RESET          = 32'd1500;
  localparam logic [TICK_W-1:0] PULSE_RESET_THROTTLE = 32'd1000;
  localparam int                THROTTLE_INDEX       = 2;

  localparam logic OP_CAPTURE = 1'b0;
  localparam logic OP_READ    = 1'b1;

  typedef struct packed {
    logic [TICK_W-1:0] sync_min;
    logic [TICK_W-1:0] sync_max;
    logic [TICK_W-1:0] data_min;
    logic [TICK_W-1:0] data_max;
  } cfg_t;

  typedef struct packed {
    logic              frame_valid;
    logic              channel_stored;
    logic [SIDX_W-1:0] stored_index;
    logic [TICK_W-1:0] stored_length;
    logic [TICK_W-1:0] read_value;
    logic              read_error;
  } result_t;

endpackage

`default_nettype wire

FILE: hdl/ppm_sum_decoder.sv
// PPM sum-signal decoder top level: config registers, input and result
// registers, and the frame tracker. Depends on ppmd_pkg and ppmd_frame.
//
// Usage:
//   Input channel (in_valid/in_stall) carries either a capture transaction
//   (op = 0, timer stamp of a falling edge) or a read transaction (op = 1,
//   channel number 1..NUM_CHANNELS). Every transaction yields exactly one
//   result on the output channel (out_valid/out_stall), in order.
//   A transaction passes two register stages, the input register and then
//   the result register. Throughput is one transaction per cycle while the
//   receiver does not stall; the only serial dependency is the frame phase,
//   valid flag, last stamp and pulse store, which update from the input register.
//   When the receiver stalls, the result register holds; the input register
//   still takes one more transaction, then in_stall rises until the result
//   is taken.
//   Configuration (cfg_write/cfg_index/cfg_data) takes effect at once; the user
//   must have it written only while the block is idle, as the block does not enforce it.
//   Reset (rst, synchronous): windows to defaults, hunting for sync, valid
//   flag clear, pulse store at 1500 ticks (channel 3 at 1000), pipeline empty.
`default_nettype none

module ppm_sum_decoder #(
  parameter int NUM_CHANNELS = ppmd_pkg::DEFAULT_NUM_CHANNELS,
  parameter int STAMP_WIDTH  = ppmd_pkg::DEFAULT_STAMP_WIDTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // configuration
  input  wire logic                           cfg_write,
  input  wire logic [ppmd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ppmd_pkg::TICK_W-1:0]    cfg_data,
  // input channel
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           op,
  input  wire logic [ppmd_pkg::TICK_W-1:0]    capture_stamp,
  input  wire logic [ppmd_pkg::CHAN_W-1:0]    read_channel,
  // output channel
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                frame_valid,
  output logic                                channel_stored,
  output logic [ppmd_pkg::SIDX_W-1:0]         stored_index,
  output logic [ppmd_pkg::TICK_W-1:0]         stored_length,
  output logic [ppmd_pkg::TICK_W-1:0]         read_value,
  output logic                                read_error
);
  import ppmd_pkg::*;

  cfg_t                   cfg;
  logic                   s1_valid;
  logic                   s1_op;
  logic [STAMP_WIDTH-1:0] s1_stamp;
  logic [CHAN_W-1:0]      s1_chan;
  logic                   advance, in_accept, item_fire;
  result_t                result;
  result_t                out_res;

  assign advance   = !out_valid || !out_stall;
  assign in_stall  = s1_valid && !advance;
  assign in_accept = in_valid && !in_stall;
  assign item_fire = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_min <= SYNC_MIN_RESET;
      cfg.sync_max <= SYNC_MAX_RESET;
      cfg.data_min <= DATA_MIN_RESET;
      cfg.data_max <= DATA_MAX_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SYNC_MIN: cfg.sync_min <= cfg_data;
        CFG_SYNC_MAX: cfg.sync_max <= cfg_data;
        CFG_DATA_MIN: cfg.data_min <= cfg_data;
        CFG_DATA_MAX: cfg.data_max <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
    if (in_accept) begin
      s1_op    <= op;
      s1_stamp <= capture_stamp[STAMP_WIDTH-1:0];
      s1_chan  <= read_channel;
    end
  end

  ppmd_frame #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .STAMP_WIDTH  (STAMP_WIDTH)
  ) u_frame (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .item_fire (item_fire),
    .op        (s1_op),
    .stamp     (s1_stamp),
    .chan      (s1_chan),
    .result    (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
    if (item_fire) begin
      out_res <= result;
    end
  end

  assign frame_valid    = out_res.frame_valid;
  assign channel_stored = out_res.channel_stored;
  assign stored_index   = out_res.stored_index;
  assign stored_length  = out_res.stored_length;
  assign read_value     = out_res.read_value;
  assign read_error     = out_res.read_error;

  a_store_or_read: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(channel_stored && read_error))
    else $error("result flags both a stored pulse and a read error");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && read_error |-> read_value == '0)
    else $error("read error with nonzero read value");

  a_fire_fills_out: assert property (@(posedge clk) disable iff (rst)
    item_fire |=> out_valid)
    else $error("processed transaction lost before result register");

endmodule

`default_nettype wire

FILE: hdl/ppmd_frame.sv
// Frame tracker: interval math, sync/data window checks, phase and valid flag,
// pulse store and read-out. Depends on ppmd_pkg.
`default_nettype none

module ppmd_frame #(
  parameter int NUM_CHANNELS = ppmd_pkg::DEFAULT_NUM_CHANNELS,
  parameter int STAMP_WIDTH  = ppmd_pkg::DEFAULT_STAMP_WIDTH
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire ppmd_pkg::cfg_t              cfg,
  input  wire logic                        item_fire,
  input  wire logic                        op,
  input  wire logic [STAMP_WIDTH-1:0]      stamp,
  input  wire logic [ppmd_pkg::CHAN_W-1:0] chan,
  output ppmd_pkg::result_t                result
);
  import ppmd_pkg::*;

  localparam int PHASE_W = $clog2(NUM_CHANNELS + 1);
  localparam int IDX_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [PHASE_W-1:0] PHASE_HUNT = PHASE_W'(NUM_CHANNELS);

  logic [PHASE_W-1:0]     phase, phase_next;
  logic [STAMP_WIDTH-1:0] last_stamp;
  logic [TICK_W-1:0]      pulse_store [NUM_CHANNELS];
  logic                   valid_flag, valid_flag_next;

  logic [STAMP_WIDTH-1:0] len;
  logic [TICK_W-1:0]      len_ticks;
  logic                   capture, hunting, sync_ok, data_ok, store_en;
  logic [PHASE_W-1:0]     phase_inc;
  logic [CHAN_W-1:0]      phase_ext;
  logic [CHAN_W-1:0]      chan_m1;
  logic [IDX_W-1:0]       rd_idx;
  logic                   rd_ok;

  // wraps modulo 2^STAMP_WIDTH by construction
  assign len       = stamp - last_stamp;
  assign len_ticks = TICK_W'(len);
  assign capture   = (op == OP_CAPTURE);
  assign hunting   = (phase >= PHASE_HUNT);
  assign sync_ok   = (len_ticks > cfg.sync_min) && (len_ticks < cfg.sync_max);
  assign data_ok   = (len_ticks > cfg.data_min) && (len_ticks < cfg.data_max);
  assign store_en  = capture && !hunting && data_ok;
  assign phase_inc = phase + PHASE_W'(1);
  assign phase_ext = CHAN_W'(phase);

  assign chan_m1 = chan - CHAN_W'(1);
  assign rd_idx  = chan_m1[IDX_W-1:0];
  assign rd_ok   = (chan >= CHAN_W'(1)) && (chan <= CHAN_W'(NUM_CHANNELS));

  always_comb begin
    phase_next      = phase;
    valid_flag_next = valid_flag;
    if (capture) begin
      if (hunting) begin
        if (sync_ok) begin
          phase_next = '0;
        end else begin
          phase_next      = PHASE_HUNT;
          valid_flag_next = 1'b0;
        end
      end else if (data_ok) begin
        phase_next = phase_inc;
        if (phase_inc == PHASE_HUNT) begin
          valid_flag_next = 1'b1;
        end
      end else begin
        phase_next      = PHASE_HUNT;
        valid_flag_next = 1'b0;
      end
    end
  end

  always_comb begin
    result                = '0;
    result.frame_valid    = valid_flag_next;
    result.channel_stored = store_en;
    if (store_en) begin
      result.stored_index  = phase_ext[SIDX_W-1:0];
      result.stored_length = len_ticks;
    end
    if (!capture) begin
      if (rd_ok) begin
        result.read_value = pulse_store[rd_idx];
      end else begin
        result.read_error = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PHASE_HUNT;
      last_stamp <= '0;
      valid_flag <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        pulse_store[i] <= (NUM_CHANNELS > THROTTLE_INDEX && i == THROTTLE_INDEX) ?
                          PULSE_RESET_THROTTLE : PULSE_RESET;
      end
    end else if (item_fire) begin
      phase      <= phase_next;
      valid_flag <= valid_flag_next;
      if (capture) begin
        last_stamp <= stamp;
      end
      if (store_en) begin
        pulse_store[phase[IDX_W-1:0]] <= len_ticks;
      end
    end
  end

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase <= PHASE_HUNT)
    else $error("frame phase beyond channel count");

  a_last_store_sets_valid: assert property (@(posedge clk) disable iff (rst)
    item_fire && store_en && (phase_inc == PHASE_HUNT) |=> valid_flag && hunting)
    else $error("last channel stored but frame not flagged valid");

  a_read_holds_state: assert property (@(posedge clk) disable iff (rst)
    item_fire && !capture |=> $stable(phase) && $stable(valid_flag) && $stable(last_stamp))
    else $error("read transaction changed frame state");

endmodule

`default_nettype wire

FILE: sim/ppm_sum_decoder_chk.sv
// Scoreboard for ppm_sum_decoder: tracks config writes and accepted transactions,
// predicts each result and compares it field by field. Depends on ppmd_pkg.
module ppm_sum_decoder_chk #(
  parameter int NUM_CHANNELS = ppmd_pkg::DEFAULT_NUM_CHANNELS,
  parameter int STAMP_WIDTH  = ppmd_pkg::DEFAULT_STAMP_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [ppmd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ppmd_pkg::TICK_W-1:0]    cfg_data,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic                           op,
  input  logic [ppmd_pkg::TICK_W-1:0]    capture_stamp,
  input  logic [ppmd_pkg::CHAN_W-1:0]    read_channel,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic                           frame_valid,
  input  logic                           channel_stored,
  input  logic [ppmd_pkg::SIDX_W-1:0]    stored_index,
  input  logic [ppmd_pkg::TICK_W-1:0]    stored_length,
  input  logic [ppmd_pkg::TICK_W-1:0]    read_value,
  input  logic                           read_error,
  output int                             fail_count,
  output int                             pending,
  output int                             pulses_stored,
  output int                             frames_done
);
  timeunit 1ns;
  timeprecision 1ps;
  import ppmd_pkg::*;

  localparam logic [63:0] STAMP_MASK = (64'd1 << STAMP_WIDTH) - 64'd1;

  cfg_t              win;
  int                phase;        // NUM_CHANNELS means hunting for sync
  logic [TICK_W-1:0] last_stamp;
  logic [TICK_W-1:0] pulse_len [NUM_CHANNELS];
  logic              valid_flag;
  result_t           expected_results [$];

  function automatic result_t ppm_decode(logic op_code, logic [TICK_W-1:0] stamp,
                                         logic [CHAN_W-1:0] chan);
    result_t           r;
    logic [TICK_W-1:0] mask;
    logic [TICK_W-1:0] interval;
    r = '0;
    mask = STAMP_MASK[TICK_W-1:0];
    if (op_code == OP_CAPTURE) begin
      interval = (stamp - last_stamp) & mask;
      last_stamp = stamp & mask;
      if (phase >= NUM_CHANNELS) begin
        if (interval > win.sync_min && interval < win.sync_max) begin
          phase = 0;
        end else begin
          phase = NUM_CHANNELS;
          valid_flag = 1'b0;
        end
      end else if (interval > win.data_min && interval < win.data_max) begin
        pulse_len[phase] = interval;
        r.channel_stored = 1'b1;
        r.stored_index = phase[SIDX_W-1:0];
        r.stored_length = interval;
        phase++;
        if (phase == NUM_CHANNELS) valid_flag = 1'b1;
      end else begin
        phase = NUM_CHANNELS;
        valid_flag = 1'b0;
      end
    end else if (chan >= 1 && chan <= NUM_CHANNELS) begin
      r.read_value = pulse_len[chan - 1];
    end else begin
      r.read_error = 1'b1;
    end
    r.frame_valid = valid_flag;
    return r;
  endfunction

  function automatic bit field_ok(string field, logic [63:0] want_v, logic [63:0] got_v);
    if (got_v === want_v) return 1'b1;
    $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, field, want_v, got_v);
    return 1'b0;
  endfunction

  always @(posedge clk) begin : watch
    result_t got;
    result_t want;
    bit      ok;
    if (rst) begin
      win = {SYNC_MIN_RESET, SYNC_MAX_RESET, DATA_MIN_RESET, DATA_MAX_RESET};
      phase = NUM_CHANNELS;
      last_stamp = '0;
      foreach (pulse_len[i]) pulse_len[i] = PULSE_RESET;
      if (NUM_CHANNELS > 2) pulse_len[THROTTLE_INDEX % NUM_CHANNELS] = PULSE_RESET_THROTTLE;
      valid_flag = 1'b0;
      expected_results.delete();
      fail_count = 0;
      pulses_stored = 0;
      frames_done = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_SYNC_MIN: win.sync_min = cfg_data;
          CFG_SYNC_MAX: win.sync_max = cfg_data;
          CFG_DATA_MIN: win.data_min = cfg_data;
          CFG_DATA_MAX: win.data_max = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        want = ppm_decode(op, capture_stamp, read_channel);
        expected_results.push_back(want);
        if (want.channel_stored) pulses_stored++;
        if (want.channel_stored && phase == NUM_CHANNELS) frames_done++;
      end
      if (out_valid && !out_stall) begin
        got = {frame_valid, channel_stored, stored_index, stored_length, read_value,
               read_error};
        if (expected_results.size() == 0) begin
          $display("%0t ns: result transaction with none expected, got 0x%0h", $time, got);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          ok = field_ok("frame_valid", want.frame_valid, got.frame_valid)
             & field_ok("channel_stored", want.channel_stored, got.channel_stored)
             & field_ok("stored_index", want.stored_index, got.stored_index)
             & field_ok("stored_length", want.stored_length, got.stored_length)
             & field_ok("read_value", want.read_value, got.read_value)
             & field_ok("read_error", want.read_error, got.read_error);
          if (!ok) fail_count++;
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

FILE: sim/ppm_sum_decoder_tb.sv
// Testbench top for ppm_sum_decoder: clock, reset, stimulus, output stalls and
// verdict. Depends on ppmd_pkg, the decoder RTL and ppm_sum_decoder_chk.
module ppm_sum_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ppmd_pkg::*;

  localparam int NUM_CHANNELS = DEFAULT_NUM_CHANNELS;
  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES  = 60;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TICK_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 op = OP_CAPTURE;
  logic [TICK_W-1:0]    capture_stamp = '0;
  logic [CHAN_W-1:0]    read_channel = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 frame_valid;
  logic                 channel_stored;
  logic [SIDX_W-1:0]    stored_index;
  logic [TICK_W-1:0]    stored_length;
  logic [TICK_W-1:0]    read_value;
  logic                 read_error;

  int                fail_count;
  int                pending;
  int                pulses_stored;
  int                frames_done;
  int                cycle_count = 0;
  int                items_sent = 0;
  int                settings_seen = 0;
  int                hold_left = 0;
  bit                sender_gaps = 1'b1;
  bit                receiver_gaps = 1'b1;
  logic [TICK_W-1:0] now_stamp = '0;   // stamp of the last capture sent
  cfg_t              win;

  always #5 clk = ~clk;

  ppm_sum_decoder u_top (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .op, .capture_stamp, .read_channel,
    .out_valid, .out_stall, .frame_valid, .channel_stored, .stored_index,
    .stored_length, .read_value, .read_error
  );

  ppm_sum_decoder_chk u_chk (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .op, .capture_stamp, .read_channel,
    .out_valid, .out_stall, .frame_valid, .channel_stored, .stored_index,
    .stored_length, .read_value, .read_error,
    .fail_count, .pending, .pulses_stored, .frames_done
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("FAIL ppm_sum_decoder");
      $finish;
    end
  end

  // output side: long hold-off when requested, otherwise random stall bursts
  always begin : receiver
    @(negedge clk);
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else if (receiver_gaps && $urandom_range(0, 4) == 0) begin
      out_stall = 1'b1;
      repeat ($urandom_range(0, 9)) @(negedge clk);
    end else begin
      out_stall = 1'b0;
    end
  end

  task automatic send(logic op_code, logic [TICK_W-1:0] stamp, logic [CHAN_W-1:0] chan);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      op = 1'($urandom_range(0, 1));
      capture_stamp = $urandom;
      read_channel = CHAN_W'($urandom);
      repeat ($urandom_range(0, 9)) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    op = op_code;
    capture_stamp = stamp;
    read_channel = chan;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic capture_gap(logic [TICK_W-1:0] gap);
    now_stamp = now_stamp + gap;
    send(OP_CAPTURE, now_stamp, CHAN_W'($urandom));
  endtask

  task automatic read_chan(logic [CHAN_W-1:0] chan);
    send(OP_READ, $urandom, chan);
  endtask

  // interval strictly inside (lo, hi); random when the window is empty
  function automatic logic [TICK_W-1:0] pick_inside(logic [TICK_W-1:0] lo,
                                                    logic [TICK_W-1:0] hi);
    logic [63:0] span;
    span = {32'd0, hi} - {32'd0, lo};
    if (span[63] || span < 2) return $urandom;
    return lo + TICK_W'({$urandom, $urandom} % (span - 1)) + 1;
  endfunction

  function automatic logic [TICK_W-1:0] pick_outside(logic [TICK_W-1:0] lo,
                                                     logic [TICK_W-1:0] hi);
    case ($urandom_range(0, 3))
      0: return lo;
      1: return hi;
      2: return hi + $urandom_range(1, 5000);
      default: return $urandom;
    endcase
  endfunction

  task automatic run_frame();
    capture_gap(pick_inside(win.sync_min, win.sync_max));
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if ($urandom_range(0, 9) == 0) read_chan(CHAN_W'($urandom));
      if ($urandom_range(0, 24) == 0) begin
        capture_gap(pick_outside(win.data_min, win.data_max));
        break;
      end
      capture_gap(pick_inside(win.data_min, win.data_max));
    end
  endtask

  task automatic run_mix(int count);
    int stop_at;
    int pick;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) read_chan(CHAN_W'($urandom));
      else if (pick < 22) capture_gap($urandom);
      else if (pick < 27) capture_gap(pick_outside(win.sync_min, win.sync_max));
      else run_frame();
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TICK_W-1:0] val);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic set_windows(logic [TICK_W-1:0] smin, logic [TICK_W-1:0] smax,
                             logic [TICK_W-1:0] dmin, logic [TICK_W-1:0] dmax);
    drain();
    write_reg(CFG_SYNC_MIN, smin);
    write_reg(CFG_SYNC_MAX, smax);
    write_reg(CFG_DATA_MIN, dmin);
    write_reg(CFG_DATA_MAX, dmax);
    win = {smin, smax, dmin, dmax};
    settings_seen++;
  endtask

  initial begin : stimulus
    logic [TICK_W-1:0] pulses [6];
    logic [TICK_W-1:0] s_lo;
    logic [TICK_W-1:0] d_lo;
    pulses = '{32'd1500, 32'd1000, 32'd1200, 32'd1800, 32'd2000, 32'd900};
    win = {SYNC_MIN_RESET, SYNC_MAX_RESET, DATA_MIN_RESET, DATA_MAX_RESET};
    settings_seen = 1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reads of the reset store, in and out of range
    read_chan(CHAN_W'(0));
    read_chan(CHAN_W'(1));
    read_chan(CHAN_W'(THROTTLE_INDEX + 1));
    read_chan(CHAN_W'(NUM_CHANNELS));
    read_chan(CHAN_W'(NUM_CHANNELS + 1));
    read_chan('1);
    // window edges are exclusive
    capture_gap(SYNC_MIN_RESET);
    capture_gap(SYNC_MAX_RESET);
    capture_gap(SYNC_MIN_RESET + 1);
    capture_gap(DATA_MIN_RESET + 1);
    capture_gap(DATA_MAX_RESET - 1);
    foreach (pulses[i]) capture_gap(pulses[i]);
    read_chan(CHAN_W'(2));
    // sync right after a full frame, then a pulse at the lower edge drops the frame
    capture_gap(SYNC_MAX_RESET - 1);
    capture_gap(DATA_MIN_RESET);
    // timer wrap: park just below zero, then a sync interval across it
    capture_gap(~now_stamp - 32'd127);
    capture_gap(32'd5000);
    capture_gap(DATA_MAX_RESET);

    run_mix(80);
    // receiver holds off while frames keep coming: the pipeline fills and stalls
    hold_left = HOLD_CYCLES;
    sender_gaps = 1'b0;
    run_frame();
    run_frame();
    sender_gaps = 1'b1;
    run_mix(40);

    // widest windows: only intervals of zero and all ones miss
    set_windows('0, '1, '0, '1);
    capture_gap('0);
    capture_gap(32'd1);
    capture_gap('1);
    capture_gap(32'd1);
    capture_gap(32'hFFFF_FFFE);
    run_mix(60);

    // empty windows: min equal to max, and max of zero
    set_windows(32'd5000, 32'd5000, '0, '0);
    capture_gap(32'd5000);
    run_mix(40);

    repeat (3) begin
      s_lo = $urandom_range(500, 20000);
      d_lo = $urandom_range(0, 3000);
      set_windows(s_lo, s_lo + $urandom_range(2, 40000), d_lo, d_lo + $urandom_range(2, 3000));
      run_mix(50);
    end

    // back to defaults, full rate on both sides
    set_windows(SYNC_MIN_RESET, SYNC_MAX_RESET, DATA_MIN_RESET, DATA_MAX_RESET);
    sender_gaps = 1'b0;
    receiver_gaps = 1'b0;
    run_mix(80);

    drain();
    repeat (5) @(posedge clk);
    $display("Sent %0d transactions over %0d window settings, with a %0d-cycle output hold-off.",
             items_sent, settings_seen, HOLD_CYCLES);
    $display("Predicted %0d stored channel pulses and %0d complete frames.",
             pulses_stored, frames_done);
    if (fail_count == 0) begin
      $display("PASS ppm_sum_decoder");
    end else begin
      $display("FAIL ppm_sum_decoder");
    end
    $finish;
  end

endmodule
